// ===== sv/atu_pkg.sv =====
// Shared constants, widths and tables for the accelerometer tilt angle unit.
// Depends on nothing; every other file of the block imports it.
`timescale 1ns / 1ps

package atu_pkg;

   localparam int ATU_SAMPLE_WIDTH  = 16;
   localparam int ATU_CORDIC_STAGES = 16;

   // angle accumulator: degrees * 32768, signed
   localparam int ANGLE_W     = 25;
   localparam int OUT_W       = 15;
   localparam int NORM_BIT    = 30;
   localparam int ANGLE_90    = 2949120;
   localparam int ROUND_HALF  = 128;
   localparam int ROUND_SHIFT = 8;
   localparam int PITCH_LIMIT = 11520;
   localparam int TILT_MAX    = 23040;
   localparam int ROOT_SCALE  = 16;
   localparam int NUM_SCALE   = 8;

   // datapath width of the rotator for a given sample width
   function automatic int atu_cordic_width(input int w);
      return (w + 11 > 34) ? w + 11 : 34;
   endfunction

   // atan(2^-i) in degrees * 32768, rounded to nearest
   function automatic logic signed [ANGLE_W-1:0] atu_atan(input int idx);
      logic signed [ANGLE_W-1:0] a;
      unique case (idx)
         0: a = 25'sd1474560;
         1: a = 25'sd870484;
         2: a = 25'sd459940;
         3: a = 25'sd233473;
         4: a = 25'sd117189;
         5: a = 25'sd58652;
         6: a = 25'sd29333;
         7: a = 25'sd14667;
         8: a = 25'sd7334;
         9: a = 25'sd3667;
         10: a = 25'sd1833;
         11: a = 25'sd917;
         12: a = 25'sd458;
         13: a = 25'sd229;
         14: a = 25'sd115;
         15: a = 25'sd57;
         16: a = 25'sd29;
         17: a = 25'sd14;
         18: a = 25'sd7;
         19: a = 25'sd4;
         20: a = 25'sd2;
         21: a = 25'sd1;
         default: a = '0;
      endcase
      return a;
   endfunction

   // round half up to degrees * 128 and clamp to the field's range
   function automatic logic [OUT_W-1:0] atu_finish(input logic signed [ANGLE_W-1:0] z,
                                                     input logic zero,
                                                     input logic is_tilt);
      logic signed [ANGLE_W-1:0] r;
      logic signed [ANGLE_W-1:0] lo;
      logic signed [ANGLE_W-1:0] hi;
      r  = (z + ANGLE_W'(ROUND_HALF)) >>> ROUND_SHIFT;
      lo = is_tilt ? '0 : -ANGLE_W'(PITCH_LIMIT);
      hi = is_tilt ? ANGLE_W'(TILT_MAX) : ANGLE_W'(PITCH_LIMIT);
      if (zero) begin
         r = '0;
      end else if (r < lo) begin
         r = lo;
      end else if (r > hi) begin
         r = hi;
      end
      return r[OUT_W-1:0];
   endfunction

endpackage

// ===== sv/atu_root.sv =====
// Pipelined integer square root, one result bit per stage, with a side value
// carried alongside. Depends on atu_pkg.
`timescale 1ns / 1ps

module atu_root
   import atu_pkg::*;
#(
   parameter int SAMPLE_WIDTH = ATU_SAMPLE_WIDTH
) (
   input  logic                                                 clock,
   input  logic                                                 reset,
   input  logic                                                 en,
   input  logic                                                 in_valid,
   input  logic [2*SAMPLE_WIDTH-1:0]                            in_sum,
   input  logic signed [atu_cordic_width(SAMPLE_WIDTH)-1:0]     in_side,
   output logic                                                 out_valid,
   output logic [SAMPLE_WIDTH+ROOT_SCALE/2-1:0]                 out_root,
   output logic signed [atu_cordic_width(SAMPLE_WIDTH)-1:0]     out_side
);

   localparam int CW = atu_cordic_width(SAMPLE_WIDTH);
   localparam int R  = SAMPLE_WIDTH + ROOT_SCALE / 2;
   localparam int VW = 2 * R + 1;

   logic [VW-1:0]        v_ff    [0:R-1];
   logic [R-1:0]         q_ff    [0:R-1];
   logic signed [CW-1:0] side_ff [0:R-1];
   logic                 vld_ff  [0:R-1];

   logic [VW-1:0]        src_v    [0:R-1];
   logic [R-1:0]         src_q    [0:R-1];
   logic signed [CW-1:0] src_side [0:R-1];
   logic                 src_vld  [0:R-1];

   logic [VW-1:0]        v_in     [0:R-1];
   logic [R-1:0]         q_in     [0:R-1];

   genvar k;
   generate
      for (k = 0; k < R; k++) begin : g_stage
         // bit decided in this stage
         localparam int B = R - 1 - k;
         logic [VW-1:0] trial;

         if (k == 0) begin : g_first
            assign src_v[k]    = VW'({in_sum, {ROOT_SCALE{1'b0}}});
            assign src_q[k]    = '0;
            assign src_side[k] = in_side;
            assign src_vld[k]  = in_valid;
         end else begin : g_next
            assign src_v[k]    = v_ff[k-1];
            assign src_q[k]    = q_ff[k-1];
            assign src_side[k] = side_ff[k-1];
            assign src_vld[k]  = vld_ff[k-1];
         end

         always_comb begin
            trial = (VW'(src_q[k]) << (B + 1)) + (VW'(1) << (2 * B));
            if (src_v[k] >= trial) begin
               v_in[k] = src_v[k] - trial;
               q_in[k] = src_q[k] | (R'(1) << B);
            end else begin
               v_in[k] = src_v[k];
               q_in[k] = src_q[k];
            end
         end

         always_ff @(posedge clock) begin
            if (reset) begin
               vld_ff[k] <= 1'b0;
            end else if (en) begin
               vld_ff[k] <= src_vld[k];
            end
            if (en) begin
               v_ff[k]    <= v_in[k];
               q_ff[k]    <= q_in[k];
               side_ff[k] <= src_side[k];
            end
         end
      end
   endgenerate

   assign out_valid = vld_ff[R-1];
   assign out_root  = q_ff[R-1];
   assign out_side  = side_ff[R-1];

endmodule

// ===== sv/atu_norm.sv =====
// Normalising shift and quadrant pre-rotation ahead of the CORDIC rotator.
// Two register stages. Depends on atu_pkg.
`timescale 1ns / 1ps

module atu_norm
   import atu_pkg::*;
#(
   parameter int SAMPLE_WIDTH = ATU_SAMPLE_WIDTH
) (
   input  logic                                             clock,
   input  logic                                             reset,
   input  logic                                             en,
   input  logic                                             in_valid,
   input  logic signed [atu_cordic_width(SAMPLE_WIDTH)-1:0] in_y,
   input  logic signed [atu_cordic_width(SAMPLE_WIDTH)-1:0] in_x,
   output logic                                             out_valid,
   output logic                                             out_zero,
   output logic signed [atu_cordic_width(SAMPLE_WIDTH)-1:0] out_y,
   output logic signed [atu_cordic_width(SAMPLE_WIDTH)-1:0] out_x,
   output logic signed [ANGLE_W-1:0]                        out_z
);

   localparam int CW = atu_cordic_width(SAMPLE_WIDTH);

   logic signed [CW-1:0]      nx_in, ny_in, nx_ff, ny_ff;
   logic                      zero_in, zero_ff, v1_ff;
   logic signed [CW-1:0]      rx_in, ry_in, rx_ff, ry_ff;
   logic signed [ANGLE_W-1:0] rz_in, rz_ff;
   logic                      rzero_ff, v2_ff;

   // shift both until the larger magnitude reaches bit NORM_BIT
   always_comb begin
      logic [CW-1:0] m;
      int            amt;
      m     = (in_x[CW-1] ? CW'(-in_x) : CW'(in_x)) | (in_y[CW-1] ? CW'(-in_y) : CW'(in_y));
      nx_in = in_x;
      ny_in = in_y;
      zero_in = (in_x == '0) && (in_y == '0);
      for (int s = 0; s < 5; s++) begin
         amt = 16 >> s;
         if (m < (CW'(1) << (NORM_BIT + 1 - amt))) begin
            m     = m << amt;
            nx_in = nx_in <<< amt;
            ny_in = ny_in <<< amt;
         end
      end
   end

   // fold the left half-plane onto the right
   always_comb begin
      rx_in = nx_ff;
      ry_in = ny_ff;
      rz_in = '0;
      if (nx_ff[CW-1]) begin
         if (!ny_ff[CW-1]) begin
            rx_in = ny_ff;
            ry_in = -nx_ff;
            rz_in = ANGLE_W'(ANGLE_90);
         end else begin
            rx_in = -ny_ff;
            ry_in = nx_ff;
            rz_in = -ANGLE_W'(ANGLE_90);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
      end else if (en) begin
         v1_ff <= in_valid;
         v2_ff <= v1_ff;
      end
      if (en) begin
         nx_ff    <= nx_in;
         ny_ff    <= ny_in;
         zero_ff  <= zero_in;
         rx_ff    <= rx_in;
         ry_ff    <= ry_in;
         rz_ff    <= rz_in;
         rzero_ff <= zero_ff;
      end
   end

   assign out_valid = v2_ff;
   assign out_zero  = rzero_ff;
   assign out_y     = ry_ff;
   assign out_x     = rx_ff;
   assign out_z     = rz_ff;

endmodule

// ===== sv/atu_cordic.sv =====
// Vectoring CORDIC rotator, one micro-rotation per register stage.
// Depends on atu_pkg for the arctangent table and widths.
`timescale 1ns / 1ps

module atu_cordic
   import atu_pkg::*;
#(
   parameter int SAMPLE_WIDTH  = ATU_SAMPLE_WIDTH,
   parameter int CORDIC_STAGES = ATU_CORDIC_STAGES
) (
   input  logic                                             clock,
   input  logic                                             reset,
   input  logic                                             en,
   input  logic                                             in_valid,
   input  logic                                             in_zero,
   input  logic signed [atu_cordic_width(SAMPLE_WIDTH)-1:0] in_y,
   input  logic signed [atu_cordic_width(SAMPLE_WIDTH)-1:0] in_x,
   input  logic signed [ANGLE_W-1:0]                        in_z,
   output logic                                             out_valid,
   output logic                                             out_zero,
   output logic signed [ANGLE_W-1:0]                        out_z
);

   localparam int CW = atu_cordic_width(SAMPLE_WIDTH);
   localparam int S  = CORDIC_STAGES;

   logic signed [CW-1:0]      x_ff [0:S-1];
   logic signed [CW-1:0]      y_ff [0:S-1];
   logic signed [ANGLE_W-1:0] z_ff [0:S-1];
   logic                      zero_ff [0:S-1];
   logic                      vld_ff  [0:S-1];

   logic signed [CW-1:0]      src_x [0:S-1];
   logic signed [CW-1:0]      src_y [0:S-1];
   logic signed [ANGLE_W-1:0] src_z [0:S-1];
   logic                      src_zero [0:S-1];
   logic                      src_vld  [0:S-1];

   logic signed [CW-1:0]      x_in [0:S-1];
   logic signed [CW-1:0]      y_in [0:S-1];
   logic signed [ANGLE_W-1:0] z_in [0:S-1];

   genvar i;
   generate
      for (i = 0; i < S; i++) begin : g_stage
         if (i == 0) begin : g_first
            assign src_x[i]    = in_x;
            assign src_y[i]    = in_y;
            assign src_z[i]    = in_z;
            assign src_zero[i] = in_zero;
            assign src_vld[i]  = in_valid;
         end else begin : g_next
            assign src_x[i]    = x_ff[i-1];
            assign src_y[i]    = y_ff[i-1];
            assign src_z[i]    = z_ff[i-1];
            assign src_zero[i] = zero_ff[i-1];
            assign src_vld[i]  = vld_ff[i-1];
         end

         // rotate towards the x axis
         always_comb begin
            if (!src_y[i][CW-1]) begin
               x_in[i] = src_x[i] + (src_y[i] >>> i);
               y_in[i] = src_y[i] - (src_x[i] >>> i);
               z_in[i] = src_z[i] + atu_atan(i);
            end else begin
               x_in[i] = src_x[i] - (src_y[i] >>> i);
               y_in[i] = src_y[i] + (src_x[i] >>> i);
               z_in[i] = src_z[i] - atu_atan(i);
            end
         end

         always_ff @(posedge clock) begin
            if (reset) begin
               vld_ff[i] <= 1'b0;
            end else if (en) begin
               vld_ff[i] <= src_vld[i];
            end
            if (en) begin
               x_ff[i]    <= x_in[i];
               y_ff[i]    <= y_in[i];
               z_ff[i]    <= z_in[i];
               zero_ff[i] <= src_zero[i];
            end
         end
      end
   endgenerate

   assign out_valid = vld_ff[S-1];
   assign out_zero  = zero_ff[S-1];
   assign out_z     = z_ff[S-1];

endmodule

// ===== sv/accel_tilt_angles_unit.sv =====
// Accelerometer tilt angle unit: pitch, roll and angle from vertical.
// Uses atu_pkg, atu_root, atu_norm and atu_cordic.
//
// Usage: one sample triple (req_accel_x/y/z, signed) enters on the request
// channel when req_valid is high and req_stall is low. Each transaction gives
// one response transaction with pitch, roll (degrees * 128, signed) and the
// angle from vertical (degrees * 128, unsigned), rounded half up and clamped.
// Throughput: one transaction per cycle while req_stall is low. From acceptance
// to rsp_valid a transaction passes the square and sum stages, SAMPLE_WIDTH + 8
// root stages, two stages of normalising shift and pre-rotation, one stage per
// CORDIC micro-rotation and the output register.
// When rsp_stall holds a response, one more result lands in a skid register
// and the pipeline freezes; req_stall is then raised until the skid drains.
// Reset (synchronous) empties the pipeline and both output registers.
`timescale 1ns / 1ps

module accel_tilt_angles_unit
   import atu_pkg::*;
#(
   parameter int SAMPLE_WIDTH  = ATU_SAMPLE_WIDTH,
   parameter int CORDIC_STAGES = ATU_CORDIC_STAGES
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_stall,
   input  logic signed [SAMPLE_WIDTH-1:0] req_accel_x,
   input  logic signed [SAMPLE_WIDTH-1:0] req_accel_y,
   input  logic signed [SAMPLE_WIDTH-1:0] req_accel_z,
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output logic signed [OUT_W-1:0]        rsp_pitch_angle,
   output logic signed [OUT_W-1:0]        rsp_roll_angle,
   output logic [OUT_W-1:0]               rsp_tilt_angle
);

   localparam int W  = SAMPLE_WIDTH;
   localparam int CW = atu_cordic_width(W);
   localparam int R  = W + ROOT_SCALE / 2;

   logic en;
   logic skid_full_ff;

   // stage 1: squares
   logic                v1_ff;
   logic signed [W-1:0] x1_ff, y1_ff, z1_ff;
   logic [2*W-2:0]      xx_ff, yy_ff, zz_ff;
   logic signed [2*W-1:0] xx_in, yy_in, zz_in;

   // stage 2: sums and scaled numerators
   logic                 v2_ff;
   logic [2*W-1:0]       syz_ff, sxz_ff, sxy_ff;
   logic signed [CW-1:0] nx_ff, py_ff, pz_ff;
   logic signed [CW-1:0] px_in;

   assign en        = !skid_full_ff;
   assign req_stall = skid_full_ff;

   assign xx_in = req_accel_x * req_accel_x;
   assign yy_in = req_accel_y * req_accel_y;
   assign zz_in = req_accel_z * req_accel_z;
   assign px_in = {{(CW-W-NUM_SCALE){x1_ff[W-1]}}, x1_ff, {NUM_SCALE{1'b0}}};

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
      end else if (en) begin
         v1_ff <= req_valid;
         v2_ff <= v1_ff;
      end
      if (en) begin
         x1_ff  <= req_accel_x;
         y1_ff  <= req_accel_y;
         z1_ff  <= req_accel_z;
         xx_ff  <= xx_in[2*W-2:0];
         yy_ff  <= yy_in[2*W-2:0];
         zz_ff  <= zz_in[2*W-2:0];
         syz_ff <= {1'b0, yy_ff} + {1'b0, zz_ff};
         sxz_ff <= {1'b0, xx_ff} + {1'b0, zz_ff};
         sxy_ff <= {1'b0, xx_ff} + {1'b0, yy_ff};
         nx_ff  <= -px_in;
         py_ff  <= {{(CW-W-NUM_SCALE){y1_ff[W-1]}}, y1_ff, {NUM_SCALE{1'b0}}};
         pz_ff  <= {{(CW-W-NUM_SCALE){z1_ff[W-1]}}, z1_ff, {NUM_SCALE{1'b0}}};
      end
   end

   // roots
   logic                 rv_p, rv_r, rv_t;
   logic [R-1:0]         root_p, root_r, root_t;
   logic signed [CW-1:0] side_p, side_r, side_t;

   atu_root #(.SAMPLE_WIDTH(W)) u_root_pitch (
      .clock, .reset, .en, .in_valid(v2_ff), .in_sum(syz_ff), .in_side(nx_ff),
      .out_valid(rv_p), .out_root(root_p), .out_side(side_p));
   atu_root #(.SAMPLE_WIDTH(W)) u_root_roll (
      .clock, .reset, .en, .in_valid(v2_ff), .in_sum(sxz_ff), .in_side(py_ff),
      .out_valid(rv_r), .out_root(root_r), .out_side(side_r));
   atu_root #(.SAMPLE_WIDTH(W)) u_root_tilt (
      .clock, .reset, .en, .in_valid(v2_ff), .in_sum(sxy_ff), .in_side(pz_ff),
      .out_valid(rv_t), .out_root(root_t), .out_side(side_t));

   logic signed [CW-1:0] ext_p, ext_r, ext_t;
   assign ext_p = CW'(root_p);
   assign ext_r = CW'(root_r);
   assign ext_t = CW'(root_t);

   // normalise and pre-rotate
   logic                      nv_p, nv_r, nv_t, nz_p, nz_r, nz_t;
   logic signed [CW-1:0]      ny_p, ny_r, ny_t, nxo_p, nxo_r, nxo_t;
   logic signed [ANGLE_W-1:0] na_p, na_r, na_t;

   atu_norm #(.SAMPLE_WIDTH(W)) u_norm_pitch (
      .clock, .reset, .en, .in_valid(rv_p), .in_y(side_p), .in_x(ext_p),
      .out_valid(nv_p), .out_zero(nz_p), .out_y(ny_p), .out_x(nxo_p), .out_z(na_p));
   atu_norm #(.SAMPLE_WIDTH(W)) u_norm_roll (
      .clock, .reset, .en, .in_valid(rv_r), .in_y(side_r), .in_x(ext_r),
      .out_valid(nv_r), .out_zero(nz_r), .out_y(ny_r), .out_x(nxo_r), .out_z(na_r));
   atu_norm #(.SAMPLE_WIDTH(W)) u_norm_tilt (
      .clock, .reset, .en, .in_valid(rv_t), .in_y(ext_t), .in_x(side_t),
      .out_valid(nv_t), .out_zero(nz_t), .out_y(ny_t), .out_x(nxo_t), .out_z(na_t));

   // rotators
   logic                      cv_p, cv_r, cv_t, cz_p, cz_r, cz_t;
   logic signed [ANGLE_W-1:0] ang_p, ang_r, ang_t;

   atu_cordic #(.SAMPLE_WIDTH(W), .CORDIC_STAGES(CORDIC_STAGES)) u_cordic_pitch (
      .clock, .reset, .en, .in_valid(nv_p), .in_zero(nz_p), .in_y(ny_p), .in_x(nxo_p),
      .in_z(na_p), .out_valid(cv_p), .out_zero(cz_p), .out_z(ang_p));
   atu_cordic #(.SAMPLE_WIDTH(W), .CORDIC_STAGES(CORDIC_STAGES)) u_cordic_roll (
      .clock, .reset, .en, .in_valid(nv_r), .in_zero(nz_r), .in_y(ny_r), .in_x(nxo_r),
      .in_z(na_r), .out_valid(cv_r), .out_zero(cz_r), .out_z(ang_r));
   atu_cordic #(.SAMPLE_WIDTH(W), .CORDIC_STAGES(CORDIC_STAGES)) u_cordic_tilt (
      .clock, .reset, .en, .in_valid(nv_t), .in_zero(nz_t), .in_y(ny_t), .in_x(nxo_t),
      .in_z(na_t), .out_valid(cv_t), .out_zero(cz_t), .out_z(ang_t));

   // output register with one skid entry
   logic             pipe_valid, out_take;
   logic [OUT_W-1:0] fin_p, fin_r, fin_t;
   logic             rsp_valid_ff;
   logic [OUT_W-1:0] skid_p_ff, skid_r_ff, skid_t_ff;
   logic [OUT_W-1:0] rsp_p_ff, rsp_r_ff, rsp_t_ff;

   assign pipe_valid = cv_p & cv_r & cv_t;
   assign fin_p      = atu_finish(ang_p, cz_p, 1'b0);
   assign fin_r      = atu_finish(ang_r, cz_r, 1'b0);
   assign fin_t      = atu_finish(ang_t, cz_t, 1'b1);
   assign out_take   = !rsp_valid_ff || !rsp_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         skid_full_ff <= 1'b0;
      end else if (skid_full_ff) begin
         if (out_take) begin
            rsp_valid_ff <= 1'b1;
            skid_full_ff <= 1'b0;
         end
      end else if (out_take) begin
         rsp_valid_ff <= pipe_valid;
      end else if (pipe_valid) begin
         skid_full_ff <= 1'b1;
      end
      if (skid_full_ff) begin
         if (out_take) begin
            rsp_p_ff <= skid_p_ff;
            rsp_r_ff <= skid_r_ff;
            rsp_t_ff <= skid_t_ff;
         end
      end else if (out_take) begin
         rsp_p_ff <= fin_p;
         rsp_r_ff <= fin_r;
         rsp_t_ff <= fin_t;
      end else begin
         // park the arriving transaction while the output is held
         skid_p_ff <= fin_p;
         skid_r_ff <= fin_r;
         skid_t_ff <= fin_t;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_pitch_angle = rsp_p_ff;
   assign rsp_roll_angle  = rsp_r_ff;
   assign rsp_tilt_angle  = rsp_t_ff;

endmodule
